>>> hdl/cpr_pkg.sv
`timescale 1ns / 1ps

package cpr_pkg;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int ANGLE_W   = 18;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd2;

    // Angles: degrees * 256 at the port, 24 fraction bits in the CORDIC
    localparam int HALF_TURN     = 180 * 256;
    localparam int FULL_TURN     = 2 * HALF_TURN;
    localparam int QUARTER_TURN  = HALF_TURN / 2;
    localparam int ANGLE_UPSHIFT = 16;

    // Coordinates: 24 fraction bits, gain removed by a constant prescale
    localparam int FRAC_BITS  = 24;
    localparam int INV_GAIN   = 652032874;
    localparam int GAIN_SHIFT = 6;

    // Arctangent table depth and default stage count
    localparam int ATAN_ENTRIES   = 24;
    localparam int DEFAULT_STAGES = 18;

    // Datapath widths
    localparam int DIFF_W = COORD_W + 1;   // point minus center
    localparam int RED_W  = ANGLE_W + 2;   // negated angle before reduction
    localparam int ZW     = 33;            // angle accumulator
    localparam int XW     = 43;            // coordinates with fraction bits
    localparam int PROD_W = 48;            // prescale product
    localparam int INT_W  = XW - FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
    } result_t;

    // atan(2^-i) in degrees with 24 fraction bits, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
        logic signed [ZW-1:0] val;
        begin
            case (idx)
                0:       val = 33'sd754974720;
                1:       val = 33'sd445687602;
                2:       val = 33'sd235489088;
                3:       val = 33'sd119537938;
                4:       val = 33'sd60000934;
                5:       val = 33'sd30029717;
                6:       val = 33'sd15018523;
                7:       val = 33'sd7509720;
                8:       val = 33'sd3754917;
                9:       val = 33'sd1877466;
                10:      val = 33'sd938734;
                11:      val = 33'sd469367;
                12:      val = 33'sd234684;
                13:      val = 33'sd117342;
                14:      val = 33'sd58671;
                15:      val = 33'sd29335;
                16:      val = 33'sd14668;
                17:      val = 33'sd7334;
                18:      val = 33'sd3667;
                19:      val = 33'sd1833;
                20:      val = 33'sd917;
                21:      val = 33'sd458;
                22:      val = 33'sd229;
                23:      val = 33'sd115;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

>>> hdl/contour_point_rotator.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle unless the skid register holds a word; stages: offset/angle fold,
// gain prescale multiply, one CORDIC iteration per stage, truncation, center add with saturation.
// A one-word skid register at the output takes the first word of a stall.
// Reset: rst_n clears all valid bits and the configuration registers to zero.
module contour_point_rotator #(
    parameter int CORDIC_STAGES = cpr_pkg::DEFAULT_STAGES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cpr_pkg::point_t                in_point,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cpr_pkg::result_t               out_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpr_pkg::ANGLE_W-1:0]    cfg_data
);
    import cpr_pkg::*;

    localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    localparam logic signed [RED_W-1:0]  HALF_R    = RED_W'(HALF_TURN);
    localparam logic signed [RED_W-1:0]  FULL_R    = RED_W'(FULL_TURN);
    localparam logic signed [RED_W-1:0]  QUARTER_R = RED_W'(QUARTER_TURN);
    localparam logic signed [PROD_W-1:0] INV_GAIN_P = PROD_W'(INV_GAIN);
    localparam logic signed [XW-1:0]     FRAC_MASK  = XW'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [INT_W:0]    SAT_MAX    = (INT_W+1)'(32767);
    localparam logic signed [INT_W:0]    SAT_MIN    = -(INT_W+1)'(32768);

    // Configuration registers
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ANGLE:    angle_reg    <= cfg_data;
                CFG_CENTER_X: center_x_reg <= cfg_data[COORD_W-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_data[COORD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline advance: frozen only while the skid register holds a word
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // Stage 1: offset from center, angle folded into one quarter turn each side
    logic signed [DIFF_W-1:0] dx_next, dy_next;
    logic signed [RED_W-1:0]  ang_next;
    logic signed [RED_W-1:0]  ang_mod;
    logic                     flip;

    always_comb
    begin
        ang_mod = -RED_W'(angle_reg);
        if (ang_mod >= HALF_R)
            ang_mod = ang_mod - FULL_R;
        else if (ang_mod < -HALF_R)
            ang_mod = ang_mod + FULL_R;

        flip     = 1'b0;
        ang_next = ang_mod;
        if (ang_mod > QUARTER_R)
        begin
            ang_next = ang_mod - HALF_R;
            flip     = 1'b1;
        end
        else if (ang_mod < -QUARTER_R)
        begin
            ang_next = ang_mod + HALF_R;
            flip     = 1'b1;
        end

        dx_next = DIFF_W'(in_point.point_x) - DIFF_W'(center_x_reg);
        dy_next = DIFF_W'(in_point.point_y) - DIFF_W'(center_y_reg);
        if (flip)
        begin
            dx_next = -dx_next;
            dy_next = -dy_next;
        end
    end

    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg;
    logic signed [RED_W-1:0]  s1_ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg  <= dx_next;
            s1_dy_reg  <= dy_next;
            s1_ang_reg <= ang_next;
        end
    end

    // Stage 2: inverse gain prescale, angle to 24 fraction bits
    logic signed [PROD_W-1:0] prod_x, prod_y;

    assign prod_x = PROD_W'(s1_dx_reg) * INV_GAIN_P;
    assign prod_y = PROD_W'(s1_dy_reg) * INV_GAIN_P;

    // CORDIC stage registers; index 0 is the prescaled input
    logic                 cv_reg [0:NSTG];
    logic signed [XW-1:0] cx_reg [0:NSTG];
    logic signed [XW-1:0] cy_reg [0:NSTG];
    logic signed [ZW-1:0] cz_reg [0:NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (en)
            cv_reg[0] <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= XW'(prod_x >>> GAIN_SHIFT);
            cy_reg[0] <= XW'(prod_y >>> GAIN_SHIFT);
            cz_reg[0] <= ZW'(s1_ang_reg) <<< ANGLE_UPSHIFT;
        end
    end

    // One rotation step per stage, direction by the sign of the residual angle
    for (genvar k = 0; k < NSTG; k++)
    begin : g_cordic
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] atan_k;

        assign xs     = cx_reg[k] >>> k;
        assign ys     = cy_reg[k] >>> k;
        assign atan_k = atan_entry(k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[k+1] <= 1'b0;
            else if (en)
                cv_reg[k+1] <= cv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[k][ZW-1])
                begin
                    cx_reg[k+1] <= cx_reg[k] - ys;
                    cy_reg[k+1] <= cy_reg[k] + xs;
                    cz_reg[k+1] <= cz_reg[k] - atan_k;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] + ys;
                    cy_reg[k+1] <= cy_reg[k] - xs;
                    cz_reg[k+1] <= cz_reg[k] + atan_k;
                end
            end
        end
    end

    // Truncate toward zero: bias negatives before the floor shift
    logic signed [XW-1:0]    xb, yb;
    logic                    tr_valid_reg;
    logic signed [INT_W-1:0] tr_x_reg, tr_y_reg;

    assign xb = cx_reg[NSTG] + (cx_reg[NSTG][XW-1] ? FRAC_MASK : '0);
    assign yb = cy_reg[NSTG] + (cy_reg[NSTG][XW-1] ? FRAC_MASK : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tr_valid_reg <= 1'b0;
        else if (en)
            tr_valid_reg <= cv_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_x_reg <= xb[XW-1:FRAC_BITS];
            tr_y_reg <= yb[XW-1:FRAC_BITS];
        end
    end

    // Add the center back and saturate to 16 bits
    logic signed [INT_W:0] sum_x, sum_y;
    result_t               res_next;

    always_comb
    begin
        sum_x = (INT_W+1)'(tr_x_reg) + (INT_W+1)'(center_x_reg);
        sum_y = (INT_W+1)'(tr_y_reg) + (INT_W+1)'(center_y_reg);

        if (sum_x > SAT_MAX)
            res_next.rotated_x = 16'sh7FFF;
        else if (sum_x < SAT_MIN)
            res_next.rotated_x = 16'sh8000;
        else
            res_next.rotated_x = sum_x[COORD_W-1:0];

        if (sum_y > SAT_MAX)
            res_next.rotated_y = 16'sh7FFF;
        else if (sum_y < SAT_MIN)
            res_next.rotated_y = 16'sh8000;
        else
            res_next.rotated_y = sum_y[COORD_W-1:0];
    end

    logic    res_valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= tr_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    // Skid register: catches the last word when the sink stalls
    result_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid_reg && !out_ready)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
            skid_reg <= res_reg;
    end

    assign out_valid  = skid_valid_reg || res_valid_reg;
    assign out_result = skid_valid_reg ? skid_reg : res_reg;

endmodule
